>>> design/i2crtm_pkg.sv
// Shared types and constants for the I2C register transaction master.
package i2crtm_pkg;

  localparam int MAX_BYTES = 16;
  localparam int BUF_AW    = $clog2(MAX_BYTES);
  localparam int CNT_W     = 5;
  localparam int TPP_W     = 10;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_BEGIN_W = 2'd2,
    CMD_BEGIN_R = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAGE_NONE   = 3'd0,
    STAGE_ADDR_W = 3'd1,
    STAGE_REG    = 3'd2,
    STAGE_DATA   = 3'd3,
    STAGE_ADDR_R = 3'd4
  } stage_t;

  typedef enum logic [4:0] {
    SQ_IDLE          = 5'd0,
    SQ_ST_SDA_HI     = 5'd1,
    SQ_ST_SCL_HI     = 5'd2,
    SQ_ST_SDA_LO     = 5'd3,
    SQ_ST_SCL_LO     = 5'd4,
    SQ_TX_BIT        = 5'd5,
    SQ_TX_SCL_HI     = 5'd6,
    SQ_TX_SCL_LO     = 5'd7,
    SQ_TX_ACK_REL    = 5'd8,
    SQ_TX_ACK_HI     = 5'd9,
    SQ_TX_ACK_SAMPLE = 5'd10,
    SQ_RX_REL        = 5'd11,
    SQ_RX_SCL_HI     = 5'd12,
    SQ_RX_SAMPLE     = 5'd13,
    SQ_RX_ACK_SET    = 5'd14,
    SQ_RX_ACK_HI     = 5'd15,
    SQ_RX_ACK_LO     = 5'd16,
    SQ_SP_SDA_LO     = 5'd17,
    SQ_SP_SCL_HI     = 5'd18,
    SQ_SP_SDA_HI     = 5'd19
  } seq_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BUS_BUSY = 2'd1;
  localparam logic [1:0] STATUS_BUS_ERR  = 2'd2;
  localparam logic [1:0] STATUS_NACK     = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [6:0]       device_address;
    logic [7:0]       register_address;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       write_byte;
    logic             sda_in;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [6:0]       device_address;
    logic [7:0]       register_address;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       write_byte;
    logic             sda_in;
  } cls_item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_read;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

endpackage

>>> design/i2crtm_front.sv
// Front end: accepts input items, classifies them and queues them for the sequencer.
module i2crtm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  i2crtm_pkg::in_item_t item,
  input  logic                 deq,
  output logic                 q_valid,
  output i2crtm_pkg::cls_item_t q_item
);
  import i2crtm_pkg::*;

  cls_item_t  cls;
  cls_item_t  q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       enq;
  logic       deq_fire;

  always_comb begin
    cls.device_address   = item.device_address;
    cls.register_address = item.register_address;
    cls.write_byte       = item.write_byte;
    cls.sda_in           = item.sda_in;
    cls.byte_count       = (item.byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES)
                                                                 : item.byte_count;
    unique case (item.cmd)
      CMD_TICK:    cls.kind = CMD_TICK;
      CMD_LOAD:    cls.kind = CMD_LOAD;
      CMD_BEGIN_W: cls.kind = CMD_BEGIN_W;
      default:     cls.kind = CMD_BEGIN_R;
    endcase
  end

  assign full     = (count == 2'd2);
  assign enq      = push && !full;
  assign q_valid  = (count != 2'd0);
  assign deq_fire = deq && q_valid;
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) wr_ptr <= ~wr_ptr;
      if (deq_fire) rd_ptr <= ~rd_ptr;
      count <= count + 2'(enq) - 2'(deq_fire);
    end
  end

endmodule

>>> design/i2crtm_back.sv
// Back end: bus sequencer, write buffer and result queue.
module i2crtm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  i2crtm_pkg::cls_item_t q_item,
  output logic                  q_take,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [9:0]            cfg_data,
  output logic                  empty,
  input  logic                  pop,
  output i2crtm_pkg::out_item_t result
);
  import i2crtm_pkg::*;

  // sequencer registers
  seq_t             seq, seq_next;
  stage_t           tx_stage, tx_stage_next;
  logic             txn_read, txn_read_next;
  logic [TPP_W-1:0] ticks_per_phase;
  logic [TPP_W-1:0] phase_counter, phase_counter_next;
  logic [3:0]       bit_counter, bit_counter_next;
  logic [7:0]       shift_register, shift_register_next;
  logic [CNT_W-1:0] byte_index, byte_index_next;
  logic [CNT_W-1:0] bytes_total, bytes_total_next;
  logic [6:0]       target_address, target_address_next;
  logic [7:0]       register_byte, register_byte_next;
  logic [CNT_W-1:0] buffer_fill, buffer_fill_next;
  logic [1:0]       sticky_status, sticky_status_next;
  logic             scl_level, scl_level_next;
  logic             sda_level, sda_level_next;
  logic [7:0]       write_buffer [MAX_BYTES];

  // result queue
  out_item_t  out_mem [2];
  logic       out_wr, out_rd;
  logic [1:0] out_cnt;
  logic       pop_fire;
  out_item_t  res;

  logic             take, idle, tick, step;
  logic [TPP_W-1:0] pc_inc, limit;
  logic [3:0]       bc_inc;
  logic [CNT_W-1:0] bi_inc;
  logic [BUF_AW-1:0] buf_idx;
  logic [7:0]       buf_rd;
  logic             snd;
  logic [7:0]       snd_val;
  stage_t           snd_stage;
  logic             last_byte;

  assign cfg_ready = 1'b1;
  assign pop_fire  = pop && (out_cnt != 2'd0);
  assign q_take    = (out_cnt != 2'd2) || pop;
  assign take      = q_valid && q_take;
  assign idle      = (seq == SQ_IDLE);
  assign tick      = take && !idle && (q_item.kind == CMD_TICK);
  assign pc_inc    = phase_counter + TPP_W'(1);
  assign limit     = (ticks_per_phase == '0) ? TPP_W'(1) : ticks_per_phase;
  assign step      = tick && (pc_inc >= limit);
  assign bc_inc    = bit_counter + 4'd1;
  assign bi_inc    = byte_index + CNT_W'(1);
  assign last_byte = (bi_inc >= bytes_total);
  // a data ack sends the byte after the current one
  assign buf_idx   = (tx_stage == STAGE_DATA) ? bi_inc[BUF_AW-1:0] : byte_index[BUF_AW-1:0];
  assign buf_rd    = write_buffer[buf_idx];

  // next state, plus the byte to load into the shifter when a send begins
  always_comb begin
    logic start_go;
    logic ack_go;
    start_go  = 1'b0;
    ack_go    = 1'b0;
    seq_next  = seq;
    snd       = 1'b0;
    snd_val   = 8'd0;
    snd_stage = tx_stage;
    if (take && idle) begin
      if (q_item.kind == CMD_BEGIN_W || q_item.kind == CMD_BEGIN_R) seq_next = SQ_ST_SDA_HI;
    end else if (step) begin
      unique case (seq)
        SQ_ST_SDA_HI:     seq_next = SQ_ST_SCL_HI;
        SQ_ST_SCL_HI:     seq_next = SQ_ST_SDA_LO;
        SQ_ST_SDA_LO: begin
          if (!q_item.sda_in) start_go = 1'b1;
          else seq_next = SQ_ST_SCL_LO;
        end
        SQ_ST_SCL_LO:     start_go = 1'b1;
        SQ_TX_BIT:        seq_next = SQ_TX_SCL_HI;
        SQ_TX_SCL_HI:     seq_next = SQ_TX_SCL_LO;
        SQ_TX_SCL_LO:     seq_next = (bc_inc >= 4'd8) ? SQ_TX_ACK_REL : SQ_TX_BIT;
        SQ_TX_ACK_REL:    seq_next = SQ_TX_ACK_HI;
        SQ_TX_ACK_HI:     seq_next = SQ_TX_ACK_SAMPLE;
        SQ_TX_ACK_SAMPLE: ack_go = 1'b1;
        SQ_RX_REL:        seq_next = SQ_RX_SCL_HI;
        SQ_RX_SCL_HI:     seq_next = SQ_RX_SAMPLE;
        SQ_RX_SAMPLE:     seq_next = (bc_inc >= 4'd8) ? SQ_RX_ACK_SET : SQ_RX_SCL_HI;
        SQ_RX_ACK_SET:    seq_next = SQ_RX_ACK_HI;
        SQ_RX_ACK_HI:     seq_next = SQ_RX_ACK_LO;
        SQ_RX_ACK_LO:     seq_next = (bi_inc < bytes_total) ? SQ_RX_REL : SQ_SP_SDA_LO;
        SQ_SP_SDA_LO:     seq_next = SQ_SP_SCL_HI;
        SQ_SP_SCL_HI:     seq_next = SQ_SP_SDA_HI;
        default:          seq_next = SQ_IDLE;
      endcase
    end

    if (start_go) begin
      snd = 1'b1;
      if (tx_stage == STAGE_REG) begin
        snd_val   = {target_address, 1'b1};
        snd_stage = STAGE_ADDR_R;
      end else begin
        snd_val   = {target_address, 1'b0};
        snd_stage = STAGE_ADDR_W;
      end
    end

    if (ack_go) begin
      unique case (tx_stage)
        STAGE_ADDR_W: begin
          snd       = 1'b1;
          snd_val   = register_byte;
          snd_stage = STAGE_REG;
        end
        STAGE_REG: begin
          if (txn_read) seq_next = SQ_ST_SDA_HI;
          else if (byte_index < bytes_total) begin
            snd       = 1'b1;
            snd_val   = buf_rd;
            snd_stage = STAGE_DATA;
          end else seq_next = SQ_SP_SDA_LO;
        end
        STAGE_DATA: begin
          if (bi_inc < bytes_total) begin
            snd       = 1'b1;
            snd_val   = buf_rd;
            snd_stage = STAGE_DATA;
          end else seq_next = SQ_SP_SDA_LO;
        end
        default: seq_next = (bytes_total != '0) ? SQ_RX_REL : SQ_SP_SDA_LO;
      endcase
    end

    if (snd) seq_next = SQ_TX_BIT;
  end

  // datapath updates and the result item
  always_comb begin
    logic [1:0] code;
    code                = STATUS_OK;
    tx_stage_next       = tx_stage;
    txn_read_next       = txn_read;
    phase_counter_next  = phase_counter;
    bit_counter_next    = bit_counter;
    shift_register_next = shift_register;
    byte_index_next     = byte_index;
    bytes_total_next    = bytes_total;
    target_address_next = target_address;
    register_byte_next  = register_byte;
    buffer_fill_next    = buffer_fill;
    sticky_status_next  = sticky_status;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    res                 = '0;

    if (take && idle) begin
      if (q_item.kind == CMD_LOAD) begin
        if (buffer_fill < CNT_W'(MAX_BYTES)) buffer_fill_next = buffer_fill + CNT_W'(1);
      end else if (q_item.kind != CMD_TICK) begin
        target_address_next = q_item.device_address;
        register_byte_next  = q_item.register_address;
        bytes_total_next    = q_item.byte_count;
        byte_index_next     = '0;
        bit_counter_next    = '0;
        shift_register_next = '0;
        phase_counter_next  = '0;
        sticky_status_next  = STATUS_OK;
        txn_read_next       = (q_item.kind == CMD_BEGIN_R);
        tx_stage_next       = STAGE_NONE;
      end
    end else if (tick) begin
      phase_counter_next = step ? '0 : pc_inc;
    end

    if (step) begin
      unique case (seq)
        SQ_ST_SDA_HI: sda_level_next = 1'b1;
        SQ_ST_SCL_HI: scl_level_next = 1'b1;
        SQ_ST_SDA_LO: begin
          if (!q_item.sda_in) code = STATUS_BUS_BUSY;
          else sda_level_next = 1'b0;
        end
        SQ_ST_SCL_LO: begin
          if (q_item.sda_in) code = STATUS_BUS_ERR;
          scl_level_next = 1'b0;
        end
        SQ_TX_BIT: begin
          scl_level_next      = 1'b0;
          sda_level_next      = shift_register[7];
          shift_register_next = {shift_register[6:0], 1'b0};
        end
        SQ_TX_SCL_HI:  scl_level_next = 1'b1;
        SQ_TX_SCL_LO: begin
          scl_level_next   = 1'b0;
          bit_counter_next = bc_inc;
        end
        SQ_TX_ACK_REL: sda_level_next = 1'b1;
        SQ_TX_ACK_HI:  scl_level_next = 1'b1;
        SQ_TX_ACK_SAMPLE: begin
          if (q_item.sda_in) code = STATUS_NACK;
          scl_level_next = 1'b0;
          if (tx_stage == STAGE_DATA) byte_index_next = bi_inc;
        end
        SQ_RX_REL: begin
          sda_level_next      = 1'b1;
          scl_level_next      = 1'b0;
          shift_register_next = '0;
          bit_counter_next    = '0;
        end
        SQ_RX_SCL_HI: scl_level_next = 1'b1;
        SQ_RX_SAMPLE: begin
          shift_register_next = {shift_register[6:0], q_item.sda_in};
          scl_level_next      = 1'b0;
          bit_counter_next    = bc_inc;
          if (bc_inc >= 4'd8) begin
            res.read_byte  = {shift_register[6:0], q_item.sda_in};
            res.read_valid = 1'b1;
            res.last_read  = last_byte;
          end
        end
        SQ_RX_ACK_SET: sda_level_next = last_byte;  // NACK on the final byte
        SQ_RX_ACK_HI:  scl_level_next = 1'b1;
        SQ_RX_ACK_LO: begin
          scl_level_next  = 1'b0;
          byte_index_next = bi_inc;
        end
        SQ_SP_SDA_LO: sda_level_next = 1'b0;
        SQ_SP_SCL_HI: scl_level_next = 1'b1;
        SQ_SP_SDA_HI: begin
          sda_level_next = 1'b1;
          if (!txn_read) buffer_fill_next = '0;
          res.done_res = 1'b1;
        end
        default: ;
      endcase
    end

    if (code != STATUS_OK && sticky_status == STATUS_OK) sticky_status_next = code;

    if (snd) begin
      shift_register_next = snd_val;
      bit_counter_next    = '0;
      tx_stage_next       = snd_stage;
    end

    res.scl_drive = scl_level_next;
    res.sda_drive = sda_level_next;
    res.busy_res  = (seq_next != SQ_IDLE);
    res.status    = sticky_status_next;
  end

  always_ff @(posedge clk) begin
    if (take && idle && q_item.kind == CMD_LOAD && buffer_fill < CNT_W'(MAX_BYTES)) begin
      write_buffer[buffer_fill[BUF_AW-1:0]] <= q_item.write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_mem[out_wr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq             <= SQ_IDLE;
      tx_stage        <= STAGE_NONE;
      txn_read        <= 1'b0;
      ticks_per_phase <= TPP_W'(1);
      phase_counter   <= '0;
      bit_counter     <= '0;
      shift_register  <= '0;
      byte_index      <= '0;
      bytes_total     <= '0;
      target_address  <= '0;
      register_byte   <= '0;
      buffer_fill     <= '0;
      sticky_status   <= STATUS_OK;
      scl_level       <= 1'b1;
      sda_level       <= 1'b1;
      out_wr          <= 1'b0;
      out_rd          <= 1'b0;
      out_cnt         <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) ticks_per_phase <= cfg_data;
      if (take) begin
        seq            <= seq_next;
        tx_stage       <= tx_stage_next;
        txn_read       <= txn_read_next;
        phase_counter  <= phase_counter_next;
        bit_counter    <= bit_counter_next;
        shift_register <= shift_register_next;
        byte_index     <= byte_index_next;
        bytes_total    <= bytes_total_next;
        target_address <= target_address_next;
        register_byte  <= register_byte_next;
        buffer_fill    <= buffer_fill_next;
        sticky_status  <= sticky_status_next;
        scl_level      <= scl_level_next;
        sda_level      <= sda_level_next;
        out_wr         <= ~out_wr;
      end
      if (pop_fire) out_rd <= ~out_rd;
      out_cnt <= out_cnt + 2'(take) - 2'(pop_fire);
    end
  end

  assign empty  = (out_cnt == 2'd0);
  assign result = out_mem[out_rd];

`ifndef SYNTHESIS
  a_out_cnt_bound: assert property (@(posedge clk) disable iff (rst) out_cnt != 2'd3)
    else $error("result queue overflow");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    buffer_fill <= CNT_W'(MAX_BYTES))
    else $error("write buffer fill past capacity");
  a_seq_hold: assert property (@(posedge clk) disable iff (rst) !take |=> $stable(seq))
    else $error("sequencer moved without an item");
  a_read_in_read_txn: assert property (@(posedge clk) disable iff (rst)
    take && res.read_valid |-> txn_read)
    else $error("received byte outside a read transaction");
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    take && res.done_res |=> seq == SQ_IDLE && !txn_read == (buffer_fill == '0) || txn_read)
    else $error("STOP completion did not return to idle");
`endif

endmodule

>>> design/i2c_register_transaction_master_unit.sv
// Top level of the I2C register transaction master: front queue and bus sequencer.
// Each item the sequencer takes does one bounded step and writes one registered result.
// Throughput: one item per cycle, unless a full result queue without a pop stalls it.
// A two-entry item queue and a two-entry result queue let either side stall alone.
// Reset (rst, synchronous): sequencer idle, lines released, queues empty, phase length 1.
// The write buffer holds no reset value; entries are valid once loaded.
module i2c_register_transaction_master_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  i2crtm_pkg::in_item_t  item,
  output logic                  empty,
  input  logic                  pop,
  output i2crtm_pkg::out_item_t result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [9:0]            cfg_data
);
  import i2crtm_pkg::*;

  logic      q_valid;
  logic      q_take;
  cls_item_t q_item;

  i2crtm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .deq     (q_take),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  i2crtm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

>>> dv/tb.sv
// Self-checking bench for the I2C register transaction master: predicted bus steps vs DUT.
module tb;
  import i2crtm_pkg::*;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [9:0] cfg_data;

  i2c_register_transaction_master_unit DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // bus sequencer mirror
  bit [9:0]  phase_len;
  seq_t      bus_state;
  bit [9:0]  phase_cnt;
  int        bit_cnt;
  bit [7:0]  shifter;
  int        byte_idx;
  int        byte_total;
  bit [6:0]  tgt_addr;
  bit [7:0]  tgt_reg;
  bit [7:0]  wbuf [MAX_BYTES];
  int        wfill;
  bit [1:0]  sticky;
  bit        scl_lv;
  bit        sda_lv;
  bit        read_txn;
  stage_t    send_stage;

  out_item_t pending_bus_outputs[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int mismatches;
  int items_sent;
  int results_checked;
  int txns_done;
  int rd_bytes;
  int status_seen [4];

  kind_t noise_cmds [3] = '{CMD_LOAD, CMD_BEGIN_W, CMD_BEGIN_R};

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic in_item_t rand_item();
    bit [31:0] raw;
    raw = $urandom;
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  function automatic void flag_status(bit [1:0] code);
    if (sticky == STATUS_OK) sticky = code;
  endfunction

  function automatic void start_shift(bit [7:0] value, stage_t stage);
    shifter = value;
    bit_cnt = 0;
    send_stage = stage;
    bus_state = SQ_TX_BIT;
  endfunction

  // after START: repeated start of a read goes to address+R
  function automatic void after_start();
    if (send_stage == STAGE_REG) start_shift({tgt_addr, 1'b1}, STAGE_ADDR_R);
    else start_shift({tgt_addr, 1'b0}, STAGE_ADDR_W);
  endfunction

  function automatic void predict_bus_outputs(in_item_t it);
    out_item_t o;
    bit [9:0]  lim;
    o = '0;
    if (bus_state == SQ_IDLE) begin
      if (it.cmd == CMD_LOAD) begin
        if (wfill < MAX_BYTES) begin
          wbuf[wfill] = it.write_byte;
          wfill++;
        end
      end else if (it.cmd == CMD_BEGIN_W || it.cmd == CMD_BEGIN_R) begin
        tgt_addr = it.device_address;
        tgt_reg = it.register_address;
        if (it.byte_count > MAX_BYTES) byte_total = MAX_BYTES;
        else byte_total = it.byte_count;
        byte_idx = 0;
        bit_cnt = 0;
        shifter = '0;
        phase_cnt = '0;
        sticky = STATUS_OK;
        read_txn = (it.cmd == CMD_BEGIN_R);
        send_stage = STAGE_NONE;
        bus_state = SQ_ST_SDA_HI;
      end
    end else if (it.cmd == CMD_TICK) begin
      lim = (phase_len == 0) ? 10'd1 : phase_len;
      phase_cnt = phase_cnt + 10'd1;
      if (phase_cnt >= lim) begin
        phase_cnt = '0;
        case (bus_state)
          SQ_ST_SDA_HI: begin sda_lv = 1'b1; bus_state = SQ_ST_SCL_HI; end
          SQ_ST_SCL_HI: begin scl_lv = 1'b1; bus_state = SQ_ST_SDA_LO; end
          SQ_ST_SDA_LO: begin
            if (!it.sda_in) begin
              // someone else holds the bus: skip the rest of START
              flag_status(STATUS_BUS_BUSY);
              after_start();
            end else begin
              sda_lv = 1'b0;
              bus_state = SQ_ST_SCL_LO;
            end
          end
          SQ_ST_SCL_LO: begin
            if (it.sda_in) flag_status(STATUS_BUS_ERR);
            scl_lv = 1'b0;
            after_start();
          end
          SQ_TX_BIT: begin
            scl_lv = 1'b0;
            sda_lv = shifter[7];
            shifter = {shifter[6:0], 1'b0};
            bus_state = SQ_TX_SCL_HI;
          end
          SQ_TX_SCL_HI: begin scl_lv = 1'b1; bus_state = SQ_TX_SCL_LO; end
          SQ_TX_SCL_LO: begin
            scl_lv = 1'b0;
            bit_cnt++;
            if (bit_cnt >= 8) bus_state = SQ_TX_ACK_REL;
            else bus_state = SQ_TX_BIT;
          end
          SQ_TX_ACK_REL: begin sda_lv = 1'b1; bus_state = SQ_TX_ACK_HI; end
          SQ_TX_ACK_HI: begin scl_lv = 1'b1; bus_state = SQ_TX_ACK_SAMPLE; end
          SQ_TX_ACK_SAMPLE: begin
            if (it.sda_in) flag_status(STATUS_NACK);
            scl_lv = 1'b0;
            case (send_stage)
              STAGE_ADDR_W: start_shift(tgt_reg, STAGE_REG);
              STAGE_REG: begin
                if (read_txn) bus_state = SQ_ST_SDA_HI;
                else if (byte_idx < byte_total) start_shift(wbuf[byte_idx], STAGE_DATA);
                else bus_state = SQ_SP_SDA_LO;
              end
              STAGE_DATA: begin
                byte_idx++;
                if (byte_idx < byte_total) start_shift(wbuf[byte_idx], STAGE_DATA);
                else bus_state = SQ_SP_SDA_LO;
              end
              default: begin
                if (byte_total > 0) bus_state = SQ_RX_REL;
                else bus_state = SQ_SP_SDA_LO;
              end
            endcase
          end
          SQ_RX_REL: begin
            sda_lv = 1'b1;
            scl_lv = 1'b0;
            shifter = '0;
            bit_cnt = 0;
            bus_state = SQ_RX_SCL_HI;
          end
          SQ_RX_SCL_HI: begin scl_lv = 1'b1; bus_state = SQ_RX_SAMPLE; end
          SQ_RX_SAMPLE: begin
            shifter = {shifter[6:0], it.sda_in};
            scl_lv = 1'b0;
            bit_cnt++;
            if (bit_cnt >= 8) begin
              o.read_byte = shifter;
              o.read_valid = 1'b1;
              o.last_read = (byte_idx + 1 >= byte_total);
              bus_state = SQ_RX_ACK_SET;
            end else begin
              bus_state = SQ_RX_SCL_HI;
            end
          end
          SQ_RX_ACK_SET: begin
            sda_lv = (byte_idx + 1 >= byte_total);  // NACK the last byte
            bus_state = SQ_RX_ACK_HI;
          end
          SQ_RX_ACK_HI: begin scl_lv = 1'b1; bus_state = SQ_RX_ACK_LO; end
          SQ_RX_ACK_LO: begin
            scl_lv = 1'b0;
            byte_idx++;
            if (byte_idx < byte_total) bus_state = SQ_RX_REL;
            else bus_state = SQ_SP_SDA_LO;
          end
          SQ_SP_SDA_LO: begin sda_lv = 1'b0; bus_state = SQ_SP_SCL_HI; end
          SQ_SP_SCL_HI: begin scl_lv = 1'b1; bus_state = SQ_SP_SDA_HI; end
          SQ_SP_SDA_HI: begin
            sda_lv = 1'b1;
            if (!read_txn) wfill = 0;
            bus_state = SQ_IDLE;
            o.done_res = 1'b1;
          end
          default: bus_state = SQ_IDLE;
        endcase
      end
    end
    o.scl_drive = scl_lv;
    o.sda_drive = sda_lv;
    o.busy_res = (bus_state != SQ_IDLE);
    o.status = sticky;
    if (o.done_res) begin
      txns_done++;
      status_seen[sticky]++;
    end
    if (o.read_valid) rd_bytes++;
    pending_bus_outputs.push_back(o);
  endfunction

  // leaves push high after acceptance so back-to-back items need no re-raise
  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    predict_bus_outputs(it);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_bus_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic set_phase_len(bit [9:0] v);
    drain();
    repeat (8) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    phase_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_byte(bit [7:0] b);
    in_item_t it;
    it = rand_item();
    it.cmd = CMD_LOAD;
    it.write_byte = b;
    send_item(it);
  endtask

  task automatic load_random(int n);
    repeat (n) load_byte(8'($urandom));
  endtask

  task automatic idle_ticks(int n);
    in_item_t it;
    repeat (n) begin
      it = rand_item();
      it.cmd = CMD_TICK;
      send_item(it);
    end
  endtask

  task automatic begin_txn(kind_t kind, bit [6:0] addr, bit [7:0] regad, bit [4:0] cnt);
    in_item_t it;
    it = rand_item();
    it.cmd = kind;
    it.device_address = addr;
    it.register_address = regad;
    it.byte_count = cnt;
    send_item(it);
  endtask

  // ticks (with optional ignored commands) until idle.
  // The SDA level mimics a target: released bus at START, ACK, random read data.
  task automatic finish_txn(int busy_pct, int err_pct, int nack_pct, int noise_pct,
                            int hold_at);
    in_item_t it;
    int       ticks;
    bit [9:0] nxt;
    ticks = 0;
    while (bus_state != SQ_IDLE) begin
      it = rand_item();
      if (roll(noise_pct)) begin
        it.cmd = noise_cmds[$urandom_range(0, 2)];
      end else begin
        it.cmd = CMD_TICK;
        nxt = phase_cnt + 10'd1;
        if (nxt >= ((phase_len == 0) ? 10'd1 : phase_len)) begin
          case (bus_state)
            SQ_ST_SDA_LO:     it.sda_in = !roll(busy_pct);
            SQ_ST_SCL_LO:     it.sda_in = roll(err_pct);
            SQ_TX_ACK_SAMPLE: it.sda_in = roll(nack_pct);
            SQ_RX_SAMPLE:     ;
            default:          it.sda_in = roll(noise_pct) ? !sda_lv : sda_lv;
          endcase
        end
        ticks++;
        if (ticks == hold_at) drain();
      end
      send_item(it);
    end
  endtask

  // one whole transaction
  task automatic run_txn(kind_t kind, bit [6:0] addr, bit [7:0] regad, bit [4:0] cnt,
                         int busy_pct, int err_pct, int nack_pct, int noise_pct,
                         int hold_at);
    begin_txn(kind, addr, regad, cnt);
    finish_txn(busy_pct, err_pct, nack_pct, noise_pct, hold_at);
  endtask

  task automatic test_idle_and_load();
    idle_ticks(3);
    load_byte(8'h00);
    load_byte(8'hFF);
    load_byte(8'hA5);
  endtask

  task automatic test_write_xfer();
    run_txn(CMD_BEGIN_W, 7'h7F, 8'h00, 5'd1, 0, 0, 0, 5, -1);
  endtask

  task automatic test_read_xfer();
    // sender holds off mid-transaction until the result side has caught up
    run_txn(CMD_BEGIN_R, 7'h55, 8'h80, 5'd1, 0, 0, 0, 0, 30);
  endtask

  task automatic test_phase_len();
    // longest phase: the counter climbs but never reaches the limit
    set_phase_len(10'd1023);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    begin_txn(CMD_BEGIN_W, 7'h70, 8'h07, 5'd0);
    idle_ticks(20);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // counter already past the shorter limit: the next tick steps
    set_phase_len(10'd2);
    finish_txn(100, 0, 0, 0, -1);
    // zero acts as one for the rest of the run
    set_phase_len(10'd0);
  endtask

  task automatic test_bus_faults();
    // zero-length read with a bus error at both STARTs
    run_txn(CMD_BEGIN_R, 7'h2A, 8'h5A, 5'd0, 0, 100, 0, 0, -1);
  endtask

  task automatic test_buffer_edges();
    load_random(MAX_BYTES + 1);  // last load hits a full buffer
    run_txn(CMD_BEGIN_W, 7'h33, 8'hC3, 5'd0, 0, 0, 100, 0, -1);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_bus_outputs.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %0h", $time, got);
      mismatches++;
    end else begin
      want = pending_bus_outputs.pop_front();
      check_field("scl_drive", 8'(want.scl_drive), 8'(got.scl_drive));
      check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      check_field("read_byte", want.read_byte, got.read_byte);
      check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
      check_field("last_read", 8'(want.last_read), 8'(got.last_read));
      check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      check_field("done_res", 8'(want.done_res), 8'(got.done_res));
      check_field("status", 8'(want.status), 8'(got.status));
      results_checked++;
    end
  endtask

  // result side
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result(result);
      @(negedge clk);
    end
  end

  initial begin
    #100000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
    phase_len = 10'd1;
    bus_state = SQ_IDLE;
    phase_cnt = '0;
    bit_cnt = 0;
    shifter = '0;
    byte_idx = 0;
    byte_total = 0;
    tgt_addr = '0;
    tgt_reg = '0;
    foreach (wbuf[i]) wbuf[i] = '0;
    wfill = 0;
    sticky = STATUS_OK;
    scl_lv = 1'b1;
    sda_lv = 1'b1;
    read_txn = 1'b0;
    send_stage = STAGE_NONE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_and_load();
    test_write_xfer();
    test_read_xfer();
    test_phase_len();
    test_bus_faults();
    test_buffer_edges();

    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d items, checked %0d results, %0d transactions, %0d bytes read.",
             items_sent, results_checked, txns_done, rd_bytes);
    $display("Status at STOP: ok %0d, bus busy %0d, bus error %0d, nack %0d.",
             status_seen[STATUS_OK], status_seen[STATUS_BUS_BUSY],
             status_seen[STATUS_BUS_ERR], status_seen[STATUS_NACK]);
    if (mismatches == 0 && pending_bus_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
